[hdl/pipm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipm_pkg
// Shared types and constants of the pulse-interval power meter.
// ----------------------------------------------------------------------------
package pipm_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned WATT_W   = 19;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [WATT_W-1:0] WATT_SCALE = WATT_W'(360000);
  localparam int unsigned       DIV_STEPS  = WATT_W;
  localparam int unsigned       DIV_CNT_W  = $clog2(DIV_STEPS);

  // event codes
  localparam logic [FUNC_W-1:0] FUNC_IMPULSE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POLL    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BURST    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_HOLD  = 8'd3;

  localparam logic [DATA_W-1:0] RST_MIN_INTERVAL = 32'd10;
  localparam logic [DATA_W-1:0] RST_MAX_INTERVAL = 32'd3600000;
  localparam logic [DATA_W-1:0] RST_MIN_BURST    = 32'd0;
  localparam logic [DATA_W-1:0] RST_STATUS_HOLD  = 32'd1000;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] diff;
    logic              borrow;  // a < b
  } alu_res_t;

endpackage

[hdl/pipm_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipm_alu
// Shared 32-bit subtractor: difference modulo 2^32 and unsigned a < b.
// ----------------------------------------------------------------------------
module pipm_alu
  import pipm_pkg::*;
(
  input  alu_op_t  op,
  output alu_res_t res
);

  logic [DATA_W:0] full;

  assign full       = {1'b0, op.a} - {1'b0, op.b};
  assign res.diff   = full[DATA_W-1:0];
  assign res.borrow = full[DATA_W];

endmodule

[hdl/pulse_interval_power_meter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_power_meter_core
// Steps: an impulse finds the gap, checks both limits, divides if in range and
// nonzero, then counts; a poll runs the burst test, then the hold test if no
// burst; clear and unused code go to output. Events are taken one at a time;
// one shared subtractor does one step per cycle, 19 of them for the quotient.
// Reset (rst_n low, synchronous): registers to defaults, readings cleared.
// ----------------------------------------------------------------------------
module pulse_interval_power_meter_core
  import pipm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [DATA_W-1:0]    in_time_ms,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WATT_W-1:0]    out_watts,
  output logic [DATA_W-1:0]    out_impulse_total,
  output logic                 out_activity
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GAP   = 4'd1;
  localparam logic [3:0] S_MAX   = 4'd2;
  localparam logic [3:0] S_MIN   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_CNT   = 4'd5;
  localparam logic [3:0] S_BURST = 4'd6;
  localparam logic [3:0] S_BCMP  = 4'd7;
  localparam logic [3:0] S_HOLD  = 4'd8;
  localparam logic [3:0] S_HCMP  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]           state_r;

  logic [DATA_W-1:0]    min_int_r, max_int_r, min_burst_r, hold_r;

  logic [DATA_W-1:0]    count_r, last_pulse_r, base_r, last_burst_r;
  logic [WATT_W-1:0]    watts_r;
  logic                 flag_r;

  logic [DATA_W-1:0]    time_r, gap_r, tmp_r;
  logic                 ok_r;
  logic [WATT_W-1:0]    rem_r, quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic                 out_valid_r, out_flag_r;
  logic [WATT_W-1:0]    out_watts_r;
  logic [DATA_W-1:0]    out_total_r;

  alu_op_t              op;
  alu_res_t             res;
  logic [WATT_W:0]      shifted;
  logic                 out_free;

  pipm_alu u_alu (
    .op  (op),
    .res (res)
  );

  assign shifted  = {rem_r, quo_r[WATT_W-1]};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    op.a = time_r;
    op.b = last_pulse_r;
    case (state_r)
      S_GAP: begin
        op.a = time_r;
        op.b = last_pulse_r;
      end
      S_MAX: begin
        op.a = gap_r;
        op.b = max_int_r;
      end
      S_MIN: begin
        op.a = gap_r;
        op.b = min_int_r;
      end
      S_DIV: begin
        op.a = DATA_W'(shifted);
        op.b = gap_r;
      end
      S_CNT: begin
        op.a = count_r;
        op.b = '1;  // a - (2^32 - 1) = a + 1
      end
      S_BURST: begin
        op.a = count_r;
        op.b = base_r;
      end
      S_BCMP: begin
        op.a = min_burst_r;
        op.b = tmp_r;
      end
      S_HOLD: begin
        op.a = time_r;
        op.b = last_burst_r;
      end
      S_HCMP: begin
        op.a = tmp_r;
        op.b = hold_r;
      end
      default: begin
        op.a = time_r;
        op.b = last_pulse_r;
      end
    endcase
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_int_r    <= RST_MIN_INTERVAL;
      max_int_r    <= RST_MAX_INTERVAL;
      min_burst_r  <= RST_MIN_BURST;
      hold_r       <= RST_STATUS_HOLD;
      count_r      <= '0;
      last_pulse_r <= '0;
      base_r       <= '0;
      last_burst_r <= '0;
      watts_r      <= '0;
      flag_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_INTERVAL: min_int_r   <= cfg_data;
          REG_MAX_INTERVAL: max_int_r   <= cfg_data;
          REG_MIN_BURST:    min_burst_r <= cfg_data;
          REG_STATUS_HOLD:  hold_r      <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_func)
              FUNC_IMPULSE: state_r <= S_GAP;
              FUNC_POLL:    state_r <= S_BURST;
              FUNC_CLEAR: begin
                watts_r <= '0;
                count_r <= '0;
                base_r  <= '0;
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_GAP: state_r <= S_MAX;
        S_MAX: state_r <= S_MIN;
        S_MIN: begin
          last_pulse_r <= time_r;
          if (ok_r && !res.borrow) begin
            if (gap_r == '0) begin
              watts_r <= WATT_SCALE;
              state_r <= S_CNT;
            end else begin
              state_r <= S_DIV;
            end
          end else begin
            watts_r <= '0;
            state_r <= S_CNT;
          end
        end
        S_DIV: begin
          if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            watts_r <= {quo_r[WATT_W-2:0], !res.borrow};
            state_r <= S_CNT;
          end
        end
        S_CNT: begin
          count_r <= res.diff;
          state_r <= S_OUT;
        end
        S_BURST: state_r <= S_BCMP;
        S_BCMP: begin
          if (res.borrow) begin
            base_r       <= count_r;
            last_burst_r <= time_r;
            flag_r       <= 1'b1;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: state_r <= S_HCMP;
        S_HCMP: begin
          if (!res.borrow) begin
            flag_r <= 1'b0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath scratch and output beat
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          time_r <= in_time_ms;
        end
      end
      S_GAP: gap_r <= res.diff;
      S_MAX: ok_r  <= res.borrow;
      S_MIN: begin
        rem_r <= '0;
        quo_r <= WATT_SCALE;
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= res.borrow ? shifted[WATT_W-1:0] : res.diff[WATT_W-1:0];
        quo_r <= {quo_r[WATT_W-2:0], !res.borrow};
        cnt_r <= cnt_r + 1'b1;
      end
      S_BURST: tmp_r <= res.diff;
      S_HOLD:  tmp_r <= res.diff;
      default: ;
    endcase
    if (state_r == S_OUT && out_free) begin
      out_watts_r <= watts_r;
      out_total_r <= count_r;
      out_flag_r  <= flag_r;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_watts         = out_watts_r;
  assign out_impulse_total = out_total_r;
  assign out_activity      = out_flag_r;

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result beat raised outside the output step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != S_IDLE)
    else $error("accepted beat left the sequencer idle");

  a_watts_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> watts_r <= WATT_SCALE)
    else $error("watts above full scale");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> cnt_r < DIV_CNT_W'(DIV_STEPS))
    else $error("divider step count overrun");

endmodule

[dv/pulse_interval_power_meter_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_power_meter_chk
// Watches the register port and both beat channels of the power meter core.
// It keeps its own copy of the meter state and the registers, works out the
// reading for each accepted event beat and compares every result beat, field
// by field and in order, with the oldest reading still due. Failures are
// counted, and the number of readings still due is handed out.
// ----------------------------------------------------------------------------
module pulse_interval_power_meter_chk
  import pipm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [DATA_W-1:0]    in_time_ms,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [WATT_W-1:0]    out_watts,
  input  logic [DATA_W-1:0]    out_impulse_total,
  input  logic                 out_activity,
  output int                   fail_cnt,
  output int                   outstanding
);

  typedef struct packed {
    logic [WATT_W-1:0] watts;
    logic [DATA_W-1:0] total;
    logic              active;
  } reading_t;

  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] last_pulse;
    logic [WATT_W-1:0] watts;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] last_burst;
    logic              active;
  } meter_t;

  meter_t            meter;
  logic [DATA_W-1:0] min_gap;
  logic [DATA_W-1:0] max_gap;
  logic [DATA_W-1:0] burst_min;
  logic [DATA_W-1:0] hold_ms;
  reading_t          due_q[$];
  int                errors  = 0;
  int                waiting = 0;

  assign fail_cnt    = errors;
  assign outstanding = waiting;

  function automatic reading_t apply_event(input logic [FUNC_W-1:0] f,
                                           input logic [DATA_W-1:0] t);
    logic [DATA_W-1:0] gap;
    logic [DATA_W-1:0] fresh;
    reading_t          r;
    gap   = t - meter.last_pulse;
    fresh = meter.count - meter.base;
    case (f)
      FUNC_IMPULSE: begin
        if (gap < max_gap && gap >= min_gap) begin
          if (gap == '0) meter.watts = WATT_SCALE;
          else meter.watts = WATT_W'(DATA_W'(WATT_SCALE) / gap);
        end else begin
          meter.watts = '0;
        end
        meter.last_pulse = t;
        meter.count      = meter.count + 1'b1;
      end
      FUNC_POLL: begin
        if (fresh > burst_min) begin
          meter.base       = meter.count;
          meter.last_burst = t;
          meter.active     = 1'b1;
        end else if (DATA_W'(t - meter.last_burst) >= hold_ms) begin
          meter.active = 1'b0;
        end
      end
      FUNC_CLEAR: begin
        meter.watts = '0;
        meter.count = '0;
        meter.base  = '0;
      end
      default: ;
    endcase
    r.watts  = meter.watts;
    r.total  = meter.count;
    r.active = meter.active;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      meter     = '0;
      min_gap   = RST_MIN_INTERVAL;
      max_gap   = RST_MAX_INTERVAL;
      burst_min = RST_MIN_BURST;
      hold_ms   = RST_STATUS_HOLD;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_INTERVAL: min_gap   = cfg_data;
          REG_MAX_INTERVAL: max_gap   = cfg_data;
          REG_MIN_BURST:    burst_min = cfg_data;
          REG_STATUS_HOLD:  hold_ms   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t ns: result beat with nothing due, expected none, actual %0d/%0d/%0d",
                   $time, out_watts, out_impulse_total, out_activity);
          errors++;
        end else begin
          want = due_q.pop_front();
          check_field("watts", want.watts, out_watts);
          check_field("impulse_total", want.total, out_impulse_total);
          check_field("activity", want.active, out_activity);
        end
      end
      if (in_valid && !in_stall) due_q.push_back(apply_event(in_func, in_time_ms));
    end
    waiting <= due_q.size();
  end

endmodule

[dv/pulse_interval_power_meter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_power_meter_core_tb
// Drives impulse, poll, clear and unused-code events into the power meter
// core under several register settings: a directed run over interval limits,
// time wrap, zero gap, empty range, activity rise and drop, then random event
// streams. Both sides idle at random and the result side holds off for a long
// stretch once. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module pulse_interval_power_meter_core_tb;
  import pipm_pkg::*;

  localparam logic [FUNC_W-1:0]    FUNC_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE      = 8'd200;
  localparam int                   CYCLE_LIMIT   = 200000;
  localparam int                   HOLD_OFF_CYC  = 300;
  localparam int                   RAND_PER_SET  = 80;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func = FUNC_IMPULSE;
  logic [DATA_W-1:0]    in_time_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WATT_W-1:0]    out_watts;
  logic [DATA_W-1:0]    out_impulse_total;
  logic                 out_activity;

  int                   fail_cnt;
  int                   outstanding;
  int                   sent_cnt = 0;
  int                   cycle_cnt = 0;
  logic                 quiet;
  logic [DATA_W-1:0]    now_ms = '0;
  logic [DATA_W-1:0]    last_imp_ms = '0;
  logic [DATA_W-1:0]    cur_min = RST_MIN_INTERVAL;
  logic [DATA_W-1:0]    cur_max = RST_MAX_INTERVAL;
  logic [DATA_W-1:0]    cur_hold = RST_STATUS_HOLD;

  assign quiet = (sent_cnt >= 200) && (sent_cnt < 280);

  pulse_interval_power_meter_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_watts         (out_watts),
    .out_impulse_total (out_impulse_total),
    .out_activity      (out_activity)
  );

  pulse_interval_power_meter_chk chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_watts         (out_watts),
    .out_impulse_total (out_impulse_total),
    .out_activity      (out_activity),
    .fail_cnt          (fail_cnt),
    .outstanding       (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off while events keep coming
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_cnt >= 60) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 19);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MIN_INTERVAL: cur_min  = val;
      REG_MAX_INTERVAL: cur_max  = val;
      REG_STATUS_HOLD:  cur_hold = val;
      default: ;
    endcase
  endtask

  // wait until every reading due has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                          input logic [DATA_W-1:0] burst, input logic [DATA_W-1:0] hold);
    settle();
    write_reg(REG_MIN_INTERVAL, lo);
    write_reg(REG_MAX_INTERVAL, hi);
    write_reg(REG_MIN_BURST, burst);
    write_reg(REG_STATUS_HOLD, hold);
  endtask

  task automatic put_event(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] t);
    in_valid   <= 1'b1;
    in_func    <= f;
    in_time_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
    if (f == FUNC_IMPULSE) last_imp_ms = t;
    now_ms = t;
    if (!quiet && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic rand_event();
    int                pick;
    logic [FUNC_W-1:0] f;
    logic [DATA_W-1:0] step;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] base;
    pick = $urandom_range(0, 99);
    if (pick < 68) f = FUNC_IMPULSE;
    else if (pick < 88) f = FUNC_POLL;
    else if (pick < 94) f = FUNC_CLEAR;
    else f = FUNC_UNUSED;
    span = (cur_max - cur_min > 20000) ? 32'd20000 : cur_max - cur_min;
    case ($urandom_range(0, 9))
      0: step = $urandom_range(0, 2);
      1: step = cur_min + $urandom_range(0, 2) - 1;
      2: step = cur_max + $urandom_range(0, 2) - 1;
      3: step = cur_hold + $urandom_range(0, 2) - 1;
      4: step = $urandom;
      5: step = $urandom_range(0, 200);
      default: begin
        if (cur_max > cur_min && span != 0) step = cur_min + $urandom_range(0, span - 1);
        else step = $urandom_range(0, 5000);
      end
    endcase
    base = (f == FUNC_IMPULSE) ? last_imp_ms : now_ms;
    put_event(f, base + step);
  endtask

  task automatic rand_run(input int n);
    repeat (n) rand_event();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // interval limits at reset settings
    put_event(FUNC_IMPULSE, 32'd0);
    put_event(FUNC_IMPULSE, 32'd5);
    put_event(FUNC_IMPULSE, 32'd15);
    put_event(FUNC_IMPULSE, 32'd3600014);
    put_event(FUNC_IMPULSE, 32'd7200014);
    // activity rise, hold, drop
    put_event(FUNC_POLL, 32'd7200100);
    put_event(FUNC_POLL, 32'd7201099);
    put_event(FUNC_POLL, 32'd7201100);
    // time wrap
    put_event(FUNC_IMPULSE, 32'hFFFF_FFF0);
    put_event(FUNC_IMPULSE, 32'h0000_0010);
    put_event(FUNC_UNUSED, 32'hFFFF_FFFF);
    put_event(FUNC_CLEAR, 32'h0000_0020);
    put_event(FUNC_POLL, 32'h0000_0030);
    put_event(FUNC_IMPULSE, 32'hFFFF_FFFF);

    // zero gap and widest range
    set_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    write_reg(REG_NONE, 32'd5);
    put_event(FUNC_IMPULSE, 32'hFFFF_FFFF);
    put_event(FUNC_IMPULSE, 32'h0000_0000);
    put_event(FUNC_IMPULSE, 32'd360001);
    put_event(FUNC_POLL, 32'd360002);

    // empty range
    set_regs(32'd100, 32'd50, 32'd2, 32'd500);
    put_event(FUNC_IMPULSE, 32'd360076);
    put_event(FUNC_IMPULSE, 32'd360276);
    put_event(FUNC_POLL, 32'd360300);

    set_regs(RST_MIN_INTERVAL, RST_MAX_INTERVAL, RST_MIN_BURST, RST_STATUS_HOLD);
    rand_run(RAND_PER_SET);
    set_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    rand_run(RAND_PER_SET);
    set_regs(32'd1, 32'd1, 32'd0, 32'hFFFF_FFFF);
    rand_run(RAND_PER_SET);
    set_regs(32'd50, 32'd2000, 32'd2, 32'd300);
    rand_run(RAND_PER_SET);
    set_regs($urandom_range(1, 500), $urandom_range(600, 100000), $urandom_range(0, 4),
             $urandom_range(0, 5000));
    rand_run(RAND_PER_SET);

    settle();
    repeat (30) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
